FILE: rtl/core/magnetometer_sample_conditioner_assert.svh
// Assertion macros for the magnetometer sample conditioner.
// Included by the checker; no other dependencies.
`ifndef MAGNETOMETER_SAMPLE_CONDITIONER_ASSERT_SVH
`define MAGNETOMETER_SAMPLE_CONDITIONER_ASSERT_SVH

// clocked check, off while reset is asserted
`define MSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/msc_pkg.sv
// Shared constants, widths and gain table for the magnetometer sample conditioner.
// No dependencies.
package msc_pkg;

	localparam int AXES    = 3;
	localparam int AXIS_W  = 2;
	localparam int RAW_W   = 16;
	localparam int VAL_W   = 17;
	localparam int MAG_W   = 26;
	localparam int DIV_W   = 11;
	localparam int CNT_W   = 5;
	localparam int GAIN_W  = 3;
	localparam int CFG_W   = 3;
	localparam int CIDX_W  = 2;

	localparam logic [9:0] SCALE = 10'd1000;

	localparam logic signed [RAW_W-1:0] MIN_RESET = 16'sd2047;
	localparam logic signed [RAW_W-1:0] MAX_RESET = -16'sd2048;
	localparam logic signed [RAW_W-1:0] OVF_RAW   = -16'sd4096;
	localparam logic signed [RAW_W-1:0] SAT_POS   = 16'sh7FFF;
	localparam logic signed [RAW_W-1:0] SAT_NEG   = 16'sh8000;

	localparam logic [CIDX_W-1:0] CFG_GAIN_INDEX = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_HARD_IRON  = 2'd1;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	function automatic logic [DIV_W-1:0] gain_divisor(input logic [GAIN_W-1:0] gain,
		input logic [AXIS_W-1:0] axis);
		logic [DIV_W-1:0] xy;
		logic [DIV_W-1:0] z;
		case (gain)
			3'd2:    begin xy = 11'd855; z = 11'd760; end
			3'd3:    begin xy = 11'd670; z = 11'd600; end
			3'd4:    begin xy = 11'd450; z = 11'd400; end
			3'd5:    begin xy = 11'd400; z = 11'd355; end
			3'd6:    begin xy = 11'd330; z = 11'd295; end
			3'd7:    begin xy = 11'd230; z = 11'd205; end
			default: begin xy = 11'd1100; z = 11'd980; end
		endcase
		return (axis == AXIS_Z) ? z : xy;
	endfunction

endpackage

FILE: rtl/core/magnetometer_sample_conditioner.sv
// Magnetometer sample conditioner: byte assembly, hard-iron offset, scaling, saturation.
// Depends on msc_pkg.
//
// One sample of six bytes is taken at a time; in_stall stays high while it is worked on.
// The three axes go in turn through one shared sequence: min/max update, midpoint,
// offset, multiply by 1000, a 26-step restoring divider (one quotient bit a cycle) and
// saturation; min/max update and offset take place only with hard-iron correction on.
// The output register is loaded with all three results once it is free or out_stall
// is low; it lets the next sample in while a result waits.
module magnetometer_sample_conditioner import msc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               x_high,
	input  logic [7:0]               x_low,
	input  logic [7:0]               z_high,
	input  logic [7:0]               z_low,
	input  logic [7:0]               y_high,
	input  logic [7:0]               y_low,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RAW_W-1:0]  x_field,
	output logic signed [RAW_W-1:0]  y_field,
	output logic signed [RAW_W-1:0]  z_field
);

	typedef enum logic [2:0] {
		S_IDLE, S_MINMAX, S_MID, S_SCALE, S_MUL, S_DIV, S_SAT, S_DONE
	} state_t;

	state_t                   state_q;
	logic [AXIS_W-1:0]        axis_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [GAIN_W-1:0]        gain_q;
	logic                     hi_en_q;
	logic signed [RAW_W-1:0]  raw_q [AXES];
	logic signed [RAW_W-1:0]  min_q [AXES];
	logic signed [RAW_W-1:0]  max_q [AXES];
	logic signed [RAW_W-1:0]  res_q [AXES];
	logic signed [RAW_W-1:0]  mid_q;
	logic signed [VAL_W-1:0]  val_q;
	logic                     neg_q;
	logic [DIV_W-1:0]         div_q;
	logic [MAG_W-1:0]         quo_q;
	logic [DIV_W-1:0]         rem_q;
	logic                     out_valid_q;
	logic signed [RAW_W-1:0]  x_q, y_q, z_q;

	logic signed [RAW_W-1:0]  raw_cur, min_cur, max_cur;
	logic signed [VAL_W-1:0]  span, mid_full, val_next, val_abs;
	logic [MAG_W-1:0]         prod;
	logic [DIV_W:0]           rem_sh;
	logic                     rem_ge;
	logic [DIV_W:0]           rem_sub;
	logic signed [RAW_W-1:0]  sat_val;

	assign raw_cur  = raw_q[axis_q];
	assign min_cur  = min_q[axis_q];
	assign max_cur  = max_q[axis_q];
	assign span     = VAL_W'(max_cur) - VAL_W'(min_cur);
	assign mid_full = VAL_W'(max_cur) - (span >>> 1);
	assign val_next = hi_en_q ? (VAL_W'(raw_cur) - VAL_W'(mid_q)) : VAL_W'(raw_cur);
	assign val_abs  = val_q[VAL_W-1] ? -val_q : val_q;
	assign prod     = MAG_W'(val_abs[RAW_W-1:0]) * MAG_W'(SCALE);
	assign rem_sh   = {rem_q, quo_q[MAG_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, div_q};
	assign rem_sub  = rem_sh - {1'b0, div_q};

	always_comb begin
		if (raw_cur == OVF_RAW) begin
			sat_val = SAT_NEG;
		end else if (neg_q) begin
			if (quo_q > MAG_W'(32768)) sat_val = SAT_NEG;
			else sat_val = RAW_W'(~quo_q[RAW_W-1:0] + 16'd1);
		end else begin
			if (quo_q > MAG_W'(32767)) sat_val = SAT_POS;
			else sat_val = quo_q[RAW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 3'd1;
			hi_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_INDEX: gain_q  <= cfg_data;
				CFG_HARD_IRON:  hi_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_X;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				min_q[i] <= MIN_RESET;
				max_q[i] <= MAX_RESET;
			end
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						raw_q[AXIS_X] <= {x_high, x_low};
						raw_q[AXIS_Y] <= {y_high, y_low};
						raw_q[AXIS_Z] <= {z_high, z_low};
						axis_q        <= AXIS_X;
						state_q       <= S_MINMAX;
					end
				end
				S_MINMAX: begin
					if (hi_en_q) begin
						if (raw_cur < min_cur) min_q[axis_q] <= raw_cur;
						if (raw_cur > max_cur) max_q[axis_q] <= raw_cur;
					end
					state_q <= S_MID;
				end
				S_MID: begin
					mid_q   <= mid_full[RAW_W-1:0];
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					val_q   <= val_next;
					state_q <= S_MUL;
				end
				S_MUL: begin
					quo_q   <= prod;
					neg_q   <= val_q[VAL_W-1];
					div_q   <= gain_divisor(gain_q, axis_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
					quo_q <= {quo_q[MAG_W-2:0], rem_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAG_W - 1)) state_q <= S_SAT;
				end
				S_SAT: begin
					res_q[axis_q] <= sat_val;
					if (axis_q == AXIS_Z) begin
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_MINMAX;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						x_q         <= res_q[AXIS_X];
						y_q         <= res_q[AXIS_Y];
						z_q         <= res_q[AXIS_Z];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign x_field   = x_q;
	assign y_field   = y_q;
	assign z_field   = z_q;

endmodule

FILE: rtl/core/msc_checker.sv
// Port-level checks for the magnetometer sample conditioner, bound to the top level.
// Depends on msc_pkg and magnetometer_sample_conditioner_assert.svh.
`include "magnetometer_sample_conditioner_assert.svh"

module msc_checker import msc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [RAW_W-1:0]  x_field,
	input logic signed [RAW_W-1:0]  y_field,
	input logic signed [RAW_W-1:0]  z_field
);

	`MSC_ASSERT(a_busy_after_item, clk, arst_n,
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall,
		"block took a second item too soon")

	`MSC_ASSERT(a_out_hold, clk, arst_n,
		out_valid && out_stall |=>
			out_valid && $stable(x_field) && $stable(y_field) && $stable(z_field),
		"stalled output item changed")

	`MSC_ASSERT(a_result_while_busy, clk, arst_n,
		$rose(out_valid) |-> $past(in_stall),
		"result item appeared without work in progress")

	`MSC_ASSERT_ALWAYS(a_reset_idle, clk,
		!arst_n |=> !out_valid && !in_stall,
		"block not idle in reset")

endmodule

bind magnetometer_sample_conditioner msc_checker u_msc_checker (.*);
